// ===== rtl/core/ibd_pkg.sv =====
// Package for the integer box downscaler: widths, register indexes and the
// transaction type passed from the front end to the back end. No dependencies.
`timescale 1ns / 1ps
package ibd_pkg;

   localparam int MaxOutWidth = 1024;
   localparam int MaxBlock    = 16;
   localparam int ColW        = $clog2(MaxOutWidth);
   localparam int FifoDepth   = 4;
   localparam int FifoIdxW    = $clog2(FifoDepth);

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_BLOCK_SIZE   = 2'd0,
      REG_OUT_WIDTH    = 2'd1,
      REG_OUT_HEIGHT   = 2'd2,
      REG_OUT_CHANNELS = 2'd3
   } reg_idx_type;

   // Effective (clamped) configuration.
   typedef struct packed {
      logic [4:0]  blk;
      logic [10:0] width;
      logic [15:0] height;
      logic        ch4;
   } cfg_type;

   // One unit of work for the back end.
   typedef struct packed {
      logic            clr_before;
      logic            clr_after;
      logic            acc;
      logic            emit;
      logic            row_last;
      logic            frame_last;
      logic            ch4;
      logic [8:0]      dsq;
      logic [ColW-1:0] col;
      logic [31:0]     pix;
   } work_type;

endpackage

// ===== rtl/core/ibd_if.sv =====
// Channel interfaces of the integer box downscaler: source pixels, output
// pixels and register writes. Depends on nothing.
`timescale 1ns / 1ps
interface ibd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_ch0;
   logic [7:0] src_ch1;
   logic [7:0] src_ch2;
   logic [7:0] src_ch3;
   logic       row_end;
   logic       frame_start;
   modport source (output valid, src_ch0, src_ch1, src_ch2, src_ch3, row_end, frame_start,
                   input ready);
   modport sink (input valid, src_ch0, src_ch1, src_ch2, src_ch3, row_end, frame_start,
                 output ready);
endinterface

interface ibd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] dst_ch0;
   logic [7:0] dst_ch1;
   logic [7:0] dst_ch2;
   logic [7:0] dst_ch3;
   logic       out_row_last;
   logic       out_frame_last;
   modport source (output valid, dst_ch0, dst_ch1, dst_ch2, dst_ch3, out_row_last,
                   out_frame_last, input ready);
   modport sink (input valid, dst_ch0, dst_ch1, dst_ch2, dst_ch3, out_row_last,
                 out_frame_last, output ready);
endinterface

interface ibd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ibd_front.sv =====
// Front end: raster counters that classify each source pixel into a work
// transaction for the back end. Depends on ibd_pkg.
`timescale 1ns / 1ps
module ibd_front (
   input  logic              clock,
   input  logic              reset,
   input  ibd_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [31:0]       in_pix,
   input  logic              in_row_end,
   input  logic              in_frame_start,
   input  logic              q_full,
   output logic              q_push,
   output ibd_pkg::work_type q_data
);
   import ibd_pkg::*;

   logic [3:0]  sub_col_ff, sub_col_in, sub_row_ff, sub_row_in;
   logic [10:0] out_col_ff, out_col_in;
   logic [15:0] out_row_ff, out_row_in;
   logic [3:0]  sc, sr;
   logic [10:0] oc;
   logic [15:0] orow;
   logic        col_last, row_last, in_range, accept;
   logic [9:0]  dsq_full;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign dsq_full = cfg.blk * cfg.blk;

   // Classify the pixel and compute the counters that follow it.
   always_comb begin
      sc   = in_frame_start ? 4'd0 : sub_col_ff;
      sr   = in_frame_start ? 4'd0 : sub_row_ff;
      oc   = in_frame_start ? 11'd0 : out_col_ff;
      orow = in_frame_start ? 16'd0 : out_row_ff;
      col_last = ({1'b0, sc} + 5'd1) >= cfg.blk;
      row_last = ({1'b0, sr} + 5'd1) >= cfg.blk;
      in_range = (orow < cfg.height) && (oc < cfg.width);

      q_data.clr_before = in_frame_start;
      q_data.clr_after  = in_row_end && row_last;
      q_data.acc        = in_range;
      q_data.emit       = in_range && col_last && row_last;
      q_data.row_last   = (oc + 11'd1) == cfg.width;
      q_data.frame_last = ((oc + 11'd1) == cfg.width) &&
                          (({1'b0, orow} + 17'd1) == {1'b0, cfg.height});
      q_data.ch4        = cfg.ch4;
      q_data.dsq        = dsq_full[8:0];
      q_data.col        = oc[ColW-1:0];
      q_data.pix        = in_pix;

      sub_row_in = sr;
      out_row_in = orow;
      if (col_last) begin
         sub_col_in = 4'd0;
         out_col_in = (oc < cfg.width) ? oc + 11'd1 : oc;
      end else begin
         sub_col_in = sc + 4'd1;
         out_col_in = oc;
      end
      if (in_row_end) begin
         sub_col_in = 4'd0;
         out_col_in = 11'd0;
         if (row_last) begin
            sub_row_in = 4'd0;
            out_row_in = (orow < cfg.height) ? orow + 16'd1 : orow;
         end else begin
            sub_row_in = sr + 4'd1;
         end
      end
   end

   assign q_push = accept && (in_range || in_frame_start || (in_row_end && row_last));

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_col_ff <= '0;
         sub_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (accept) begin
         sub_col_ff <= sub_col_in;
         sub_row_ff <= sub_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end
endmodule

// ===== rtl/core/ibd_fifo.sv =====
// Short queue of work transactions between front end and back end.
// Depends on ibd_pkg.
`timescale 1ns / 1ps
module ibd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ibd_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output ibd_pkg::work_type head
);
   import ibd_pkg::*;

   work_type              slot_ff [FifoDepth];
   logic [FifoIdxW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FifoIdxW:0]     cnt_ff, cnt_in;

   assign full  = cnt_ff == (FifoIdxW + 1)'(FifoDepth);
   assign empty = cnt_ff == '0;
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (FifoIdxW + 1)'(push) - (FifoIdxW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule

// ===== rtl/core/ibd_back.sv =====
// Back end: read-modify-write of the line store of block sums, iterative
// division by D squared and the output register. Depends on ibd_pkg.
`timescale 1ns / 1ps
module ibd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  ibd_pkg::work_type q_head,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [31:0]       out_pix,
   output logic              out_row_last,
   output logic              out_frame_last
);
   import ibd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   work_type      cur_ff;
   logic [63:0]   sums_mem [MaxOutWidth];
   logic [63:0]   rd_ff;
   logic [ColW:0] fill_ff, fill_in;
   logic [63:0]   old_sum, new_sum;
   logic [63:0]   quo_ff, quo_in;
   logic [35:0]   rem_ff, rem_in;
   logic [3:0]    step_ff, step_in;
   logic          old_valid, sum_wr, load_out;
   logic          out_valid_ff;
   logic [31:0]   out_pix_ff;
   logic          out_row_ff, out_frame_ff;
   logic [9:0]    trial;
   logic [8:0]    rem_ch;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign old_valid = {1'b0, cur_ff.col} < fill_ff;
   assign old_sum   = old_valid ? rd_ff : 64'd0;
   assign sum_wr    = (state_ff == ST_SUM) && cur_ff.acc;
   assign load_out  = (state_ff == ST_OUT) && (!out_valid_ff || out_ready);

   // Add the pixel to the stored block sums; channel 3 only with 4 channels.
   always_comb begin
      new_sum[15:0]  = old_sum[15:0]  + {8'd0, cur_ff.pix[7:0]};
      new_sum[31:16] = old_sum[31:16] + {8'd0, cur_ff.pix[15:8]};
      new_sum[47:32] = old_sum[47:32] + {8'd0, cur_ff.pix[23:16]};
      new_sum[63:48] = cur_ff.ch4 ? old_sum[63:48] + {8'd0, cur_ff.pix[31:24]}
                                  : old_sum[63:48];
   end

   // One restoring division step for each of the four channels.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int c = 0; c < 4; c++) begin
         trial = {rem_ff[c*9 +: 9], quo_ff[c*16 + 15]};
         if (trial >= {1'b0, cur_ff.dsq}) begin
            rem_ch = 9'(trial - {1'b0, cur_ff.dsq});
            quo_in[c*16 +: 16] = {quo_ff[c*16 +: 15], 1'b1};
         end else begin
            rem_ch = trial[8:0];
            quo_in[c*16 +: 16] = {quo_ff[c*16 +: 15], 1'b0};
         end
         rem_in[c*9 +: 9] = rem_ch;
      end
   end

   // Sequencer and fill count of the line store.
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_SUM;
               if (q_head.clr_before) begin
                  fill_in = '0;
               end
            end
         end
         ST_SUM: begin
            state_in = ST_IDLE;
            if (cur_ff.acc && !old_valid) begin
               fill_in = {1'b0, cur_ff.col} + 1'b1;
            end
            if (cur_ff.acc && cur_ff.emit) begin
               state_in = ST_DIV;
               step_in  = '0;
            end
            if (cur_ff.clr_after) begin
               fill_in = '0;
            end
         end
         ST_DIV: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         step_ff  <= step_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Line store: read on pop, written back after the add.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= sums_mem[q_head.col];
      end
      if (sum_wr) begin
         sums_mem[cur_ff.col] <= new_sum;
      end
   end

   // Working registers and the output register.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (state_ff == ST_SUM) begin
         quo_ff <= new_sum;
         rem_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (load_out) begin
         out_pix_ff   <= {cur_ff.ch4 ? quo_ff[55:48] : 8'd0, quo_ff[39:32],
                          quo_ff[23:16], quo_ff[7:0]};
         out_row_ff   <= cur_ff.row_last;
         out_frame_ff <= cur_ff.frame_last;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_pix        = out_pix_ff;
   assign out_row_last   = out_row_ff;
   assign out_frame_last = out_frame_ff;
endmodule

// ===== rtl/core/integer_box_downscale.sv =====
// Integer box downscaler top level: configuration registers, front end,
// work queue and back end. Depends on ibd_pkg, ibd_if, ibd_front, ibd_fifo, ibd_back.
// A block-completing pixel passes the work queue and back end states IDLE, SUM, DIV, OUT
// before its output is registered. The line store read-modify-write (IDLE, SUM) sets the
// pixel rate; the back end holds new items until that output loads. The queue absorbs bursts.
// Reset: counters clear, the line store reads as zero (fill count), registers 2/1024/1/4.
`timescale 1ns / 1ps
module integer_box_downscale (
   input logic     clock,
   input logic     reset,
   ibd_req_if.sink   req_if,
   ibd_rsp_if.source rsp_if,
   ibd_csr_if.sink   csr_if
);
   import ibd_pkg::*;

   logic [4:0]  blk_ff;
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  chan_ff;
   cfg_type     cfg;
   work_type    push_data, head;
   logic        push, full, pop, empty;
   logic [31:0] rsp_pix;

   // Register writes are always taken.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff    <= 5'd2;
         width_ff  <= 11'd1024;
         height_ff <= 16'd1;
         chan_ff   <= 3'd4;
      end else if (csr_if.valid) begin
         case (reg_idx_type'(csr_if.index))
            REG_BLOCK_SIZE:   blk_ff    <= csr_if.data[4:0];
            REG_OUT_WIDTH:    width_ff  <= csr_if.data[10:0];
            REG_OUT_HEIGHT:   height_ff <= csr_if.data;
            REG_OUT_CHANNELS: chan_ff   <= csr_if.data[2:0];
            default: ;
         endcase
      end
   end

   // Clamp the registers to their working ranges.
   always_comb begin
      if (blk_ff == 5'd0) cfg.blk = 5'd1;
      else if (blk_ff > 5'(MaxBlock)) cfg.blk = 5'(MaxBlock);
      else cfg.blk = blk_ff;
      if (width_ff == 11'd0) cfg.width = 11'd1;
      else if (width_ff > 11'(MaxOutWidth)) cfg.width = 11'(MaxOutWidth);
      else cfg.width = width_ff;
      cfg.height = (height_ff == 16'd0) ? 16'd1 : height_ff;
      cfg.ch4    = chan_ff != 3'd3;
   end

   ibd_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(req_if.valid), .in_ready(req_if.ready),
      .in_pix({req_if.src_ch3, req_if.src_ch2, req_if.src_ch1, req_if.src_ch0}),
      .in_row_end(req_if.row_end), .in_frame_start(req_if.frame_start),
      .q_full(full), .q_push(push), .q_data(push_data)
   );

   ibd_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data), .full(full),
      .pop(pop), .empty(empty), .head(head)
   );

   ibd_back u_back (
      .clock(clock), .reset(reset), .q_empty(empty), .q_pop(pop), .q_head(head),
      .out_valid(rsp_if.valid), .out_ready(rsp_if.ready), .out_pix(rsp_pix),
      .out_row_last(rsp_if.out_row_last), .out_frame_last(rsp_if.out_frame_last)
   );

   assign rsp_if.dst_ch0 = rsp_pix[7:0];
   assign rsp_if.dst_ch1 = rsp_pix[15:8];
   assign rsp_if.dst_ch2 = rsp_pix[23:16];
   assign rsp_if.dst_ch3 = rsp_pix[31:24];
endmodule
